FILE: rtl/core/dco_pkg.sv
package dco_pkg;

	localparam int FRAME_WIDTH   = 640;
	localparam int FRAME_HEIGHT  = 480;

	localparam int DEPTH_W = 11;
	localparam int COLOR_W = 8;
	localparam int BW_W    = 12;
	localparam int BAND_W  = 8;
	localparam int COL_W   = 10;
	localparam int ROW_W   = 9;
	localparam int RGB_W   = 3 * COLOR_W;

	localparam int PALETTE_DEPTH = 1 << DEPTH_W;
	localparam int WARM_W        = $clog2(FRAME_WIDTH + 1);
	localparam int DIV_STEPS     = DEPTH_W;

	localparam logic [BW_W-1:0] BAND_WIDTH_RESET = 12'd45;

	localparam logic ACT_PIXEL  = 1'b0;
	localparam logic ACT_PAL_WR = 1'b1;

	typedef struct packed {
		logic               action;
		logic [DEPTH_W-1:0] depth;
		logic [DEPTH_W-1:0] dvd;
		logic [BW_W-1:0]    rem;
		logic [DEPTH_W-1:0] quo;
		logic [RGB_W-1:0]   rgb;
	} item_t;

	typedef struct packed {
		logic               we;
		logic               re;
		logic [DEPTH_W-1:0] addr;
		logic [RGB_W-1:0]   wdata;
	} pal_ctrl_t;

	typedef struct packed {
		logic             pvalid;
		logic             contour;
		logic             last;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} meta_t;

endpackage

FILE: rtl/core/dco_if.sv
interface dco_pix_if;
	logic                        valid;
	logic                        ready;
	logic                        action;
	logic [dco_pkg::DEPTH_W-1:0] depth;
	logic [dco_pkg::COLOR_W-1:0] in_red;
	logic [dco_pkg::COLOR_W-1:0] in_green;
	logic [dco_pkg::COLOR_W-1:0] in_blue;

	modport source (output valid, action, depth, in_red, in_green, in_blue, input ready);
	modport sink (input valid, action, depth, in_red, in_green, in_blue, output ready);
endinterface

interface dco_res_if;
	logic                        valid;
	logic                        ready;
	logic [dco_pkg::COLOR_W-1:0] out_red;
	logic [dco_pkg::COLOR_W-1:0] out_green;
	logic [dco_pkg::COLOR_W-1:0] out_blue;
	logic                        on_contour;
	logic                        pixel_valid;
	logic [dco_pkg::COL_W-1:0]   column;
	logic [dco_pkg::ROW_W-1:0]   row;
	logic                        frame_end;

	modport source (output valid, out_red, out_green, out_blue, on_contour, pixel_valid,
		column, row, frame_end, input ready);
	modport sink (input valid, out_red, out_green, out_blue, on_contour, pixel_valid,
		column, row, frame_end, output ready);
endinterface

interface dco_cfg_if;
	logic                     valid;
	logic                     ready;
	logic [dco_pkg::BW_W-1:0] band_width;

	modport source (output valid, band_width, input ready);
	modport sink (input valid, band_width, output ready);
endinterface

FILE: rtl/core/dco_div_cell.sv
module dco_div_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic [dco_pkg::BW_W-1:0] divisor,
	input  logic                     vld_in,
	input  dco_pkg::item_t           item_in,
	output logic                     vld_q,
	output dco_pkg::item_t           item_q
);

	logic [dco_pkg::BW_W:0] trial;
	logic [dco_pkg::BW_W:0] diff;
	logic                   take;
	dco_pkg::item_t         item_nxt;

	// one restoring quotient bit
	always_comb begin
		trial        = {item_in.rem, item_in.dvd[dco_pkg::DEPTH_W-1]};
		take         = trial >= {1'b0, divisor};
		diff         = trial - {1'b0, divisor};
		item_nxt     = item_in;
		item_nxt.rem = take ? diff[dco_pkg::BW_W-1:0] : trial[dco_pkg::BW_W-1:0];
		item_nxt.quo = {item_in.quo[dco_pkg::DEPTH_W-2:0], take};
		item_nxt.dvd = {item_in.dvd[dco_pkg::DEPTH_W-2:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_q <= item_nxt;
		end
	end

endmodule

FILE: rtl/core/dco_window.sv
module dco_window (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                vld_in,
	input  dco_pkg::item_t      item_in,
	output dco_pkg::pal_ctrl_t  pal,
	output logic                out_vld_q,
	output dco_pkg::meta_t      meta_q
);

	localparam int W = dco_pkg::FRAME_WIDTH;
	localparam int H = dco_pkg::FRAME_HEIGHT;

	logic [dco_pkg::BAND_W-1:0]  band_line_q [2*W];
	logic [dco_pkg::DEPTH_W-1:0] depth_line_q [W];
	logic [dco_pkg::COL_W-1:0]   col_q;
	logic [dco_pkg::ROW_W-1:0]   row_q;
	logic [dco_pkg::WARM_W-1:0]  warm_q;

	logic                        is_pix;
	logic                        is_wr;
	logic [dco_pkg::BAND_W-1:0]  band;
	logic [dco_pkg::BAND_W-1:0]  center;
	logic [dco_pkg::BAND_W-1:0]  up;
	logic [dco_pkg::BAND_W-1:0]  left;
	logic [dco_pkg::BAND_W-1:0]  right;
	logic [dco_pkg::ROW_W-1:0]   r_out;
	logic                        col_end;
	logic                        interior;
	logic                        differ;
	logic                        pvalid;
	dco_pkg::meta_t              meta_nxt;

	always_comb begin
		is_pix   = vld_in && (item_in.action == dco_pkg::ACT_PIXEL);
		is_wr    = vld_in && (item_in.action == dco_pkg::ACT_PAL_WR);
		band     = item_in.quo[dco_pkg::BAND_W-1:0];
		// taps: row r at c, row r-1 at c, row r at c-1 and c+1
		center   = band_line_q[W-1];
		up       = band_line_q[2*W-1];
		left     = band_line_q[W];
		right    = band_line_q[W-2];
		r_out    = (row_q == '0) ? dco_pkg::ROW_W'(H - 1) : row_q - 1'b1;
		col_end  = col_q == dco_pkg::COL_W'(W - 1);
		pvalid   = warm_q == dco_pkg::WARM_W'(W);
		interior = (r_out != '0) && (r_out != dco_pkg::ROW_W'(H - 1)) &&
			(col_q != '0) && !col_end;
		differ   = (center != left) || (center != right) || (center != up) ||
			(center != band);

		meta_nxt.pvalid  = pvalid;
		meta_nxt.contour = pvalid && interior && differ;
		meta_nxt.last    = pvalid && col_end && (r_out == dco_pkg::ROW_W'(H - 1));
		meta_nxt.col     = col_q;
		meta_nxt.row     = r_out;

		pal.we    = adv && is_wr;
		pal.re    = adv && is_pix;
		pal.addr  = is_wr ? item_in.depth : depth_line_q[W-1];
		pal.wdata = item_in.rgb;
	end

	always_ff @(posedge clk) begin
		if (adv && is_pix) begin
			band_line_q[0]  <= band;
			depth_line_q[0] <= item_in.depth;
			for (int i = 1; i < 2 * W; i++) begin
				band_line_q[i] <= band_line_q[i-1];
			end
			for (int i = 1; i < W; i++) begin
				depth_line_q[i] <= depth_line_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			warm_q    <= '0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= is_pix;
			if (is_pix) begin
				if (col_end) begin
					col_q <= '0;
					row_q <= (row_q == dco_pkg::ROW_W'(H - 1)) ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
				if (!pvalid) begin
					warm_q <= warm_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_q <= meta_nxt;
		end
	end

endmodule

FILE: rtl/core/dco_pal_ram.sv
module dco_pal_ram (
	input  logic                      clk,
	input  dco_pkg::pal_ctrl_t        ctrl,
	output logic [dco_pkg::RGB_W-1:0] rd_q
);

	logic [dco_pkg::RGB_W-1:0] mem [dco_pkg::PALETTE_DEPTH];

	always_ff @(posedge clk) begin
		if (ctrl.we) begin
			mem[ctrl.addr] <= ctrl.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.re) begin
			rd_q <= mem[ctrl.addr];
		end
	end

endmodule

FILE: rtl/core/depth_contour_overlay_core.sv
// depth contour overlay
// pix_in carries raster-order items: a depth pixel (action 0) or a palette
// write (action 1, depth is the entry index, in_red/in_green/in_blue the colour).
// res_out gives one item per depth pixel, none per palette write; each result
// is the pixel one row above the pixel that released it, so the last row of a
// frame comes out while the next frame goes in. cfg writes band_width, always
// ready; write it only while the block is idle.
// an accepted item passes the 11-cell restoring divider chain (one quotient bit
// per cell) and then the line-buffer/palette stage before it reaches res_out.
// throughput: one item per cycle while res_out is not stalled; the cells, the
// two line buffers and the palette read all advance together.
// when res_out is stalled the whole chain holds and pix_in.ready drops; a held
// result stays on res_out until taken.
// reset clears the position counters and valid bits; band_width returns to 45.
// the first row of results after reset has pixel_valid low with zero colour.
// palette entries must be written before a pixel reads them.
module depth_contour_overlay_core (
	input  logic      clk,
	input  logic      arst_n,
	dco_pix_if.sink   pix_in,
	dco_res_if.source res_out,
	dco_cfg_if.sink   cfg
);

	logic [dco_pkg::BW_W-1:0]  band_width_q;
	logic [dco_pkg::BW_W-1:0]  divisor;
	logic                      adv;
	logic                      stage_vld  [dco_pkg::DIV_STEPS+1];
	dco_pkg::item_t            stage_item [dco_pkg::DIV_STEPS+1];
	dco_pkg::pal_ctrl_t        pal;
	logic                      out_vld_q;
	dco_pkg::meta_t            meta_q;
	logic [dco_pkg::RGB_W-1:0] pal_rd_q;
	logic                      blank;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_width_q <= dco_pkg::BAND_WIDTH_RESET;
		end else if (cfg.valid && cfg.ready) begin
			band_width_q <= cfg.band_width;
		end
	end

	// zero band width acts as one
	assign divisor = (band_width_q == '0) ? dco_pkg::BW_W'(1) : band_width_q;

	assign adv          = !out_vld_q || res_out.ready;
	assign pix_in.ready = adv;

	always_comb begin
		stage_vld[0]        = pix_in.valid;
		stage_item[0].action = pix_in.action;
		stage_item[0].depth  = pix_in.depth;
		stage_item[0].dvd    = pix_in.depth;
		stage_item[0].rem    = '0;
		stage_item[0].quo    = '0;
		stage_item[0].rgb    = {pix_in.in_red, pix_in.in_green, pix_in.in_blue};
	end

	for (genvar g = 0; g < dco_pkg::DIV_STEPS; g++) begin : g_div
		dco_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.divisor (divisor),
			.vld_in  (stage_vld[g]),
			.item_in (stage_item[g]),
			.vld_q   (stage_vld[g+1]),
			.item_q  (stage_item[g+1])
		);
	end

	dco_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.vld_in    (stage_vld[dco_pkg::DIV_STEPS]),
		.item_in   (stage_item[dco_pkg::DIV_STEPS]),
		.pal       (pal),
		.out_vld_q (out_vld_q),
		.meta_q    (meta_q)
	);

	dco_pal_ram u_pal (
		.clk  (clk),
		.ctrl (pal),
		.rd_q (pal_rd_q)
	);

	assign blank = !meta_q.pvalid || meta_q.contour;

	assign res_out.valid       = out_vld_q;
	assign res_out.out_red     = blank ? '0 : pal_rd_q[dco_pkg::RGB_W-1 -: dco_pkg::COLOR_W];
	assign res_out.out_green   = blank ? '0 : pal_rd_q[dco_pkg::COLOR_W +: dco_pkg::COLOR_W];
	assign res_out.out_blue    = blank ? '0 : pal_rd_q[dco_pkg::COLOR_W-1:0];
	assign res_out.on_contour  = meta_q.contour;
	assign res_out.pixel_valid = meta_q.pvalid;
	assign res_out.column      = meta_q.col;
	assign res_out.row         = meta_q.row;
	assign res_out.frame_end   = meta_q.last;

	a_contour_black: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid && res_out.on_contour |->
			res_out.out_red == '0 && res_out.out_green == '0 && res_out.out_blue == '0)
		else $error("contour pixel not black");

	a_warmup_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid && !res_out.pixel_valid |->
			!res_out.on_contour && !res_out.frame_end && res_out.out_red == '0 &&
			res_out.out_green == '0 && res_out.out_blue == '0)
		else $error("warmup item carries data");

	a_frame_end_pos: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid && res_out.frame_end |->
			res_out.column == dco_pkg::COL_W'(dco_pkg::FRAME_WIDTH - 1) &&
			res_out.row == dco_pkg::ROW_W'(dco_pkg::FRAME_HEIGHT - 1))
		else $error("frame end away from last pixel");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		pal.we |=> !res_out.valid || $past(!adv) || $past(pal.re))
		else $error("palette write produced a result");

endmodule
